/* rtl/zeckendorf_encoder_top_macros.svh */
// assertion macros for the zeckendorf encoder
`ifndef ZECKENDORF_ENCODER_TOP_MACROS_SVH
`define ZECKENDORF_ENCODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, clocked on clk_i, off during reset
`define ZECK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zeck assertion failed");
// next-cycle implication, clocked on clk_i, off during reset
`define ZECK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zeck assertion failed");
`else
`define ZECK_ASSERT_NOW(lbl, ante, cons)
`define ZECK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/zeck_pkg.sv */
`default_nettype none

package zeck_pkg;

  // width of the digit count field
  localparam int COUNT_W = 6;

  // control from the sequencer to the descent datapath
  typedef struct packed {
    logic load;
    logic step;
  } zeck_ctrl_t;

  // fibonacci number F(n), F(1) = F(2) = 1, evaluated at elaboration
  function automatic logic [63:0] fib(input int n);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    a = 64'd0;
    b = 64'd1;
    for (int i = 0; i < n; i++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

/* rtl/zeck_core.sv */
`default_nettype none

module zeck_core #(
  parameter int MAX_DIGITS = 39,
  parameter int K_WIDTH    = 27
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire zeck_pkg::zeck_ctrl_t      ctrl_i,
  input  wire logic [K_WIDTH-1:0]        k_value_i,
  output logic                           last_o,
  output logic [MAX_DIGITS-1:0]          digits_o,
  output logic [zeck_pkg::COUNT_W-1:0]   count_o,
  output logic                           bad_o
);
  import zeck_pkg::*;

  // weight of the top position and its neighbor below
  localparam logic [63:0] TOP_W64  = fib(MAX_DIGITS + 1);
  localparam logic [63:0] NEXT_W64 = fib(MAX_DIGITS);
  localparam int WW = $clog2(TOP_W64 + 64'd1);
  localparam int CW = (WW > K_WIDTH) ? WW : K_WIDTH;
  localparam int JW = $clog2(MAX_DIGITS);
  localparam logic [WW-1:0] TOP_W  = TOP_W64[WW-1:0];
  localparam logic [WW-1:0] NEXT_W = NEXT_W64[WW-1:0];

  logic [K_WIDTH-1:0]    rem_q, rem_d, rem_next;
  logic [WW-1:0]         fa_q, fa_d, fb_q, fb_d;
  logic [MAX_DIGITS-1:0] dig_q, dig_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;
  logic [JW-1:0]         j_q, j_d;
  logic                  zero_q, zero_d;
  logic [CW-1:0]         rem_ext, fa_ext;
  logic                  take;

  // compare-subtract of the current weight against the remainder
  assign rem_ext  = CW'(rem_q);
  assign fa_ext   = CW'(fa_q);
  assign take     = rem_ext >= fa_ext;
  assign rem_next = take ? K_WIDTH'(rem_ext - fa_ext) : rem_q;

  // next values: load a new transaction or descend one position
  always_comb begin
    rem_d  = rem_q;
    fa_d   = fa_q;
    fb_d   = fb_q;
    dig_d  = dig_q;
    cnt_d  = cnt_q;
    j_d    = j_q;
    zero_d = zero_q;
    if (ctrl_i.load) begin
      rem_d  = k_value_i;
      fa_d   = TOP_W;
      fb_d   = NEXT_W;
      dig_d  = '0;
      cnt_d  = '0;
      j_d    = JW'(MAX_DIGITS - 1);
      zero_d = (k_value_i == '0);
    end else if (ctrl_i.step) begin
      rem_d = rem_next;
      fa_d  = fb_q;
      fb_d  = fa_q - fb_q;
      dig_d = {dig_q[MAX_DIGITS-2:0], take};
      if (cnt_q == '0 && take) begin
        cnt_d = COUNT_W'(j_q) + COUNT_W'(1);
      end
      j_d = j_q - JW'(1);
    end
  end

  // position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else begin
      j_q <= j_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    fa_q   <= fa_d;
    fb_q   <= fb_d;
    dig_q  <= dig_d;
    cnt_q  <= cnt_d;
    zero_q <= zero_d;
  end

  // result as it stands after the current step
  assign last_o   = (j_q == '0);
  assign digits_o = dig_d;
  assign count_o  = cnt_d;
  assign bad_o    = zero_q || (rem_next != '0);

endmodule

`default_nettype wire

/* rtl/zeckendorf_encoder_top.sv */
// channel   direction  handshake            payload
// command   in         start, busy          k_value_i
// result    out        done_o (one cycle)   digits_o, digit_count_o, bad_input_o
//
// a transaction is taken when start is high and busy is low
// the descent visits one fibonacci position per cycle on one compare-subtract unit
// busy drops in the strobe cycle, so a new transaction can be taken then
// the receiver cannot stall, results are shown once
// reset clears the sequencer, the strobe and j_q; other datapath registers are not reset
`default_nettype none

`include "zeckendorf_encoder_top_macros.svh"

module zeckendorf_encoder_top #(
  parameter int MAX_DIGITS = 39,
  parameter int K_WIDTH    = 27
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [K_WIDTH-1:0]        k_value_i,
  output logic                           done_o,
  output logic [MAX_DIGITS-1:0]          digits_o,
  output logic [zeck_pkg::COUNT_W-1:0]   digit_count_o,
  output logic                           bad_input_o
);
  import zeck_pkg::*;

  zeck_ctrl_t            ctrl;
  logic                  running_q, running_d;
  logic                  done_q, done_d;
  logic                  last;
  logic [MAX_DIGITS-1:0] core_digits;
  logic [COUNT_W-1:0]    core_count;
  logic                  core_bad;
  logic [MAX_DIGITS-1:0] digits_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  bad_q;
  logic                  finish;

  // sequencer control
  assign ctrl.load = start && !running_q;
  assign ctrl.step = running_q;
  assign finish    = running_q && last;

  always_comb begin
    running_d = running_q;
    if (ctrl.load) begin
      running_d = 1'b1;
    end else if (finish) begin
      running_d = 1'b0;
    end
    done_d = finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
    end
  end

  // greedy descent datapath
  zeck_core #(
    .MAX_DIGITS (MAX_DIGITS),
    .K_WIDTH    (K_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .k_value_i (k_value_i),
    .last_o    (last),
    .digits_o  (core_digits),
    .count_o   (core_count),
    .bad_o     (core_bad)
  );

  // result registers, cleared fields on a bad input
  always_ff @(posedge clk_i) begin
    if (finish) begin
      digits_q <= core_bad ? '0 : core_digits;
      count_q  <= core_bad ? '0 : core_count;
      bad_q    <= core_bad;
    end
  end

  assign busy          = running_q;
  assign done_o        = done_q;
  assign digits_o      = digits_q;
  assign digit_count_o = count_q;
  assign bad_input_o   = bad_q;

  // checks
  `ZECK_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ZECK_ASSERT_NOW(a_done_idle, done_o, !busy)
  `ZECK_ASSERT_NOW(a_bad_clear, done_o && bad_input_o, digits_o == '0 && digit_count_o == '0)
  `ZECK_ASSERT_NOW(a_no_adjacent, done_o, (digits_o & (digits_o >> 1)) == '0)

endmodule

`default_nettype wire
